@@ rtl/assert_macros.svh @@
// Assertion macros used by the checker file.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

@@ rtl/tpst_pkg.sv @@
// Types and codes for the trajectory point search table.
// No dependencies.
package tpst_pkg;
  localparam logic [2:0] OP_APPEND  = 3'd0;
  localparam logic [2:0] OP_NEAREST = 3'd1;
  localparam logic [2:0] OP_MARGIN  = 3'd2;
  localparam logic [2:0] OP_TIME    = 3'd3;
  localparam logic [2:0] OP_CLEAR   = 3'd4;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [2:0]         opcode;
    logic signed [23:0] point_x;
    logic signed [23:0] point_y;
    logic signed [23:0] time_value;
    logic [39:0]        margin;
  } req_t;

  typedef struct packed {
    logic [7:0] index;
    logic [1:0] status;
    logic [8:0] point_count;
  } rsp_t;
endpackage

@@ rtl/tpst_if.sv @@
// Valid/ready channel interfaces for requests and results.
// Depends on tpst_pkg.
interface tpst_req_if;
  import tpst_pkg::*;
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface tpst_rsp_if;
  import tpst_pkg::*;
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ rtl/tpst_front.sv @@
// Front end: two-entry request queue decoupling intake from the scan engine.
// Depends on tpst_pkg.
module tpst_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  tpst_pkg::req_t  in_req,
  output logic            q_valid,
  input  logic            q_pop,
  output tpst_pkg::req_t  q_req
);
  import tpst_pkg::*;

  req_t       mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       push;

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_req    = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= in_req;
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (q_pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, q_pop};
    end
  end
endmodule

@@ rtl/tpst_back.sv @@
// Back end: point memories and a one-point-per-cycle scan engine.
// Depends on tpst_pkg.
module tpst_back #(
  parameter int DEPTH = 256
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_valid,
  output logic            q_pop,
  input  tpst_pkg::req_t  q_req,
  output logic            out_valid,
  input  logic            out_ready,
  output tpst_pkg::rsp_t  out_rsp
);
  import tpst_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_CMP  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic signed [23:0] xm [DEPTH];
  logic signed [23:0] ym [DEPTH];
  logic signed [23:0] tm [DEPTH];

  logic [2:0]         state_r, state_nxt;
  logic [CW-1:0]      count_r;
  req_t               req_r;
  logic [CW-1:0]      rd_r;       // address being read
  logic               rd_en;
  logic signed [23:0] xd_r, yd_r, td_r;
  logic               rdv_r;      // read data valid
  logic [AW-1:0]      rdi_r;      // index of read data
  logic               rdl_r;      // read data is last point
  logic signed [24:0] dx_r, dy_r;
  logic               mv_r, ml_r;
  logic [AW-1:0]      mi_r;
  logic [49:0]        sx_r, sy_r;
  logic signed [23:0] tq_r;
  logic               pv_r, pl_r; // squares stage valid / last
  logic [AW-1:0]      pi_r;
  logic signed [23:0] pt_r;
  logic [50:0]        best_r;
  logic               have_r, found_r;
  logic [AW-1:0]      idx_r;
  logic [50:0]        dist_cur;
  logic [51:0]        lim;
  logic               take;
  rsp_t               rsp_r;
  logic               ov_r;

  assign q_pop     = (state_r == S_IDLE) && q_valid && !ov_r;
  assign out_valid = ov_r;
  assign out_rsp   = rsp_r;
  assign rd_en     = (state_r == S_RD);
  assign dist_cur  = {1'b0, sx_r} + {1'b0, sy_r};
  assign lim       = {1'b0, best_r} + {12'd0, req_r.margin};

  always_comb begin
    if (!have_r) take = 1'b1;
    else if (req_r.opcode == OP_NEAREST) take = dist_cur < best_r;
    else take = {1'b0, dist_cur} < lim;
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_req.opcode == OP_APPEND && count_r < DEPTH_C) begin
      xm[count_r[AW-1:0]] <= q_req.point_x;
      ym[count_r[AW-1:0]] <= q_req.point_y;
      tm[count_r[AW-1:0]] <= q_req.time_value;
    end
    xd_r <= xm[rd_r[AW-1:0]];
    yd_r <= ym[rd_r[AW-1:0]];
    td_r <= tm[rd_r[AW-1:0]];
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (q_pop) begin
        if ((q_req.opcode == OP_NEAREST || q_req.opcode == OP_MARGIN ||
             q_req.opcode == OP_TIME) && count_r != '0)
          state_nxt = S_RD;
        else
          state_nxt = S_IDLE;
      end
      S_RD:   if (rd_r == count_r - 1'b1) state_nxt = S_MUL;
      S_MUL:  state_nxt = S_CMP;
      S_CMP:  if (!pv_r && !mv_r && !rdv_r) state_nxt = S_DONE;
      S_DONE: if (!ov_r) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    rdv_r <= rd_en;
    rdi_r <= rd_r[AW-1:0];
    rdl_r <= rd_en && (rd_r == count_r - 1'b1);
    dx_r  <= 25'(xd_r) - 25'(req_r.point_x);
    dy_r  <= 25'(yd_r) - 25'(req_r.point_y);
    tq_r  <= td_r;
    mv_r  <= rdv_r;
    mi_r  <= rdi_r;
    ml_r  <= rdl_r;
    sx_r  <= 50'(dx_r * dx_r);
    sy_r  <= 50'(dy_r * dy_r);
    pv_r  <= mv_r;
    pi_r  <= mi_r;
    pl_r  <= ml_r;
    pt_r  <= tq_r;
    if (q_pop) req_r <= q_req;
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      ov_r    <= 1'b0;
      rd_r    <= '0;
      have_r  <= 1'b0;
      found_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (ov_r && out_ready) ov_r <= 1'b0;
      if (rd_en) rd_r <= rd_r + 1'b1;
      if (q_pop) begin
        rd_r    <= '0;
        have_r  <= 1'b0;
        found_r <= 1'b0;
        idx_r   <= '0;
        rsp_r.index  <= '0;
        case (q_req.opcode)
          OP_APPEND: begin
            if (count_r < DEPTH_C) begin
              count_r <= count_r + 1'b1;
              rsp_r.status <= ST_OK;
              rsp_r.point_count <= 9'(count_r + 1'b1);
            end else begin
              rsp_r.status <= ST_FULL;
              rsp_r.point_count <= 9'(count_r);
            end
            ov_r <= 1'b1;
          end
          OP_CLEAR: begin
            count_r <= '0;
            rsp_r.status <= ST_OK;
            rsp_r.point_count <= '0;
            ov_r <= 1'b1;
          end
          OP_NEAREST, OP_MARGIN, OP_TIME: begin
            rsp_r.point_count <= 9'(count_r);
            if (count_r == '0) begin
              rsp_r.status <= ST_EMPTY;
              ov_r <= 1'b1;
            end else begin
              rsp_r.status <= ST_OK;
            end
          end
          default: begin
            rsp_r.status <= ST_OK;
            rsp_r.point_count <= 9'(count_r);
            ov_r <= 1'b1;
          end
        endcase
      end
      if (pv_r && state_r != S_IDLE) begin
        if (req_r.opcode == OP_TIME) begin
          if (pl_r) begin
            if (req_r.time_value >= pt_r || !found_r) idx_r <= pi_r;
          end else if (!found_r && pt_r >= req_r.time_value) begin
            idx_r   <= pi_r;
            found_r <= 1'b1;
          end
        end else if (take) begin
          best_r <= dist_cur;
          idx_r  <= pi_r;
          have_r <= 1'b1;
        end
      end
      if (state_r == S_DONE && !ov_r) begin
        rsp_r.index <= 8'(idx_r);
        ov_r <= 1'b1;
      end
    end
  end
endmodule

@@ rtl/trajectory_point_search_table.sv @@
// Top level of the trajectory point search table.
// Depends on tpst_pkg, tpst_if, tpst_front and tpst_back.
//
// Usage:
//   in_* channel carries one request: opcode (append, nearest, nearest with
//   margin, time lower bound, clear), a query or new point and a margin.
//   out_* channel returns one result per request: index, status, count.
//   A two-entry request queue feeds the scan engine, so requests are taken
//   while the engine works or while a result waits.
// Sequencing:
//   append, clear, empty query and unused opcodes: the result is registered
//   from the request; the next request is taken once it is accepted.
//   nearest, margin and time queries: the engine reads one point per cycle
//   from the point memories through read, difference, square and compare
//   stages, then registers the index; a new request waits for the result.
// Reset:
//   rst_n low empties the table and the queue; point memory is not cleared.
// Backpressure:
//   a stalled result holds out_valid and its data; the engine waits and the
//   queue fills, then in_ready drops.
module trajectory_point_search_table #(
  parameter int DEPTH = 256
) (
  input logic clk,
  input logic rst_n,
  tpst_req_if.sink   in_ch,
  tpst_rsp_if.source out_ch
);
  import tpst_pkg::*;

  logic q_valid, q_pop;
  req_t q_req;

  tpst_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .in_req   (in_ch.data),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_req    (q_req)
  );

  tpst_back #(.DEPTH(DEPTH)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_req     (q_req),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_rsp   (out_ch.data)
  );
endmodule

@@ rtl/tpst_checker.sv @@
// Port-level checks for the trajectory point search table, with bind.
// Depends on tpst_pkg and assert_macros.svh.
`include "assert_macros.svh"
module tpst_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           in_ready,
  input logic           out_valid,
  input logic           out_ready,
  input tpst_pkg::rsp_t out_data
);
  import tpst_pkg::*;

  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data))
  `ASSERT_IMPL(a_status_code, clk, rst_n, out_valid, out_data.status != 2'd3)
  `ASSERT_IMPL(a_empty_idx, clk, rst_n, out_valid && out_data.status == ST_EMPTY, out_data.index == 8'd0 && out_data.point_count == 9'd0)
  `ASSERT_IMPL(a_full_idx, clk, rst_n, out_valid && out_data.status == ST_FULL, out_data.index == 8'd0)
  `ASSERT_NEXT(a_reset_idle, clk, 1'b1, !rst_n, !out_valid && in_ready)
endmodule

bind trajectory_point_search_table tpst_checker u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_data  (out_ch.data)
);
